FILE: sv/esdpb_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// EEPROM shadow store with dirty page bits. No dependencies.
package esdpb_pkg;

  // Store geometry
  localparam int MEM_BYTES   = 256;
  localparam int PAGE_BYTES  = 16;
  localparam int BLOCK_BYTES = 16;
  localparam int NPAGES      = (MEM_BYTES + PAGE_BYTES - 1) / PAGE_BYTES;
  localparam int NBLOCKS     = MEM_BYTES / BLOCK_BYTES;
  localparam int MEM_AW      = $clog2(MEM_BYTES);
  localparam int PAGE_AW     = $clog2(PAGE_BYTES);
  localparam int BLK_AW      = $clog2(BLOCK_BYTES);
  localparam int PG_W        = $clog2(NPAGES);
  localparam int IDX_W       = (BLK_AW > PG_W) ? BLK_AW : PG_W;

  // Command codes
  localparam logic [2:0] CMD_READ   = 3'd0;
  localparam logic [2:0] CMD_WRITE  = 3'd1;
  localparam logic [2:0] CMD_FILL   = 3'd2;
  localparam logic [2:0] CMD_BLK_RD = 3'd3;
  localparam logic [2:0] CMD_BLK_WR = 3'd4;
  localparam logic [2:0] CMD_COPY   = 3'd5;
  localparam logic [2:0] CMD_COMMIT = 3'd6;
  localparam logic [2:0] CMD_FLUSH  = 3'd7;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD     = 2'd1;
  localparam logic [1:0] ST_BUSY    = 2'd2;
  localparam logic [1:0] ST_REFUSED = 2'd3;

  // Kinds of result beat
  localparam logic [2:0] EK_OK     = 3'd0;
  localparam logic [2:0] EK_ERR    = 3'd1;
  localparam logic [2:0] EK_BUSY   = 3'd2;
  localparam logic [2:0] EK_BYTE   = 3'd3;
  localparam logic [2:0] EK_COMMIT = 3'd4;
  localparam logic [2:0] EK_FLUSH  = 3'd5;

  // Read address select
  localparam logic [1:0] RS_BYTE = 2'd0;
  localparam logic [1:0] RS_BWB  = 2'd1;
  localparam logic [1:0] RS_BLK  = 2'd2;
  localparam logic [1:0] RS_SRC  = 2'd3;

  // Write kinds
  localparam logic [1:0] WK_NONE = 2'd0;
  localparam logic [1:0] WK_MARK = 2'd1;
  localparam logic [1:0] WK_FILL = 2'd2;
  localparam logic [1:0] WK_COPY = 2'd3;

  typedef struct packed {
    logic       load;
    logic       rd_en;
    logic [1:0] rsel;
    logic [1:0] wk;
    logic       idx_inc;
    logic       emit;
    logic [2:0] kind;
    logic       last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       addr_ok;
    logic       blk_ok;
    logic       off_ok;
    logic       src_ok;
    logic       busy;
    logic       idx_last;
    logic       out_free;
    logic       any_dirty;
    logic       flush_dirty;
    logic       flush_more;
  } dp_status_t;

endpackage

FILE: sv/eeprom_shadow_dirty_page_buffer.sv
// Read, write, fill, block write: decode, store read, then the result beat;
// errors, commit and busy flush go from decode to the beat. No new command is
// taken until the item ends. Block read streams 16 beats at one per cycle
// while the output is free; copy reads, then writes, each byte; flush walks
// pages one per cycle and gives one beat per dirty page once the output is free.
// Reset clears valid bits, dirty bits and commit pointer at once; no sweep.
module eeprom_shadow_dirty_page_buffer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] cmd,
  input  logic [9:0] address,
  input  logic [7:0] block,
  input  logic [3:0] offset,
  input  logic [7:0] src_block,
  input  logic [7:0] value,
  input  logic       device_busy,
  input  logic       device_accepts,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] data,
  output logic [3:0] page,
  output logic       page_write,
  output logic [1:0] status,
  output logic       last
);
  import esdpb_pkg::*;

  ctrl_cmd_t  c;
  dp_status_t st;

  esdpb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .c        (c)
  );

  esdpb_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .c              (c),
    .st             (st),
    .cmd            (cmd),
    .address        (address),
    .block          (block),
    .offset         (offset),
    .src_block      (src_block),
    .value          (value),
    .device_busy    (device_busy),
    .device_accepts (device_accepts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .data           (data),
    .page           (page),
    .page_write     (page_write),
    .status         (status),
    .last           (last)
  );

endmodule

FILE: sv/esdpb_dp.sv
// Datapath: input latch, byte store with valid bits, dirty bits, commit
// pointer, walk counter and result register. Depends on esdpb_pkg.
module esdpb_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  esdpb_pkg::ctrl_cmd_t   c,
  output esdpb_pkg::dp_status_t  st,
  input  logic [2:0]             cmd,
  input  logic [9:0]             address,
  input  logic [7:0]             block,
  input  logic [3:0]             offset,
  input  logic [7:0]             src_block,
  input  logic [7:0]             value,
  input  logic                   device_busy,
  input  logic                   device_accepts,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             data,
  output logic [3:0]             page,
  output logic                   page_write,
  output logic [1:0]             status,
  output logic                   last
);
  import esdpb_pkg::*;

  // Latched item
  logic [2:0] cmd_q;
  logic [9:0] address_q;
  logic [7:0] block_q;
  logic [3:0] offset_q;
  logic [7:0] src_q;
  logic [7:0] value_q;
  logic       busy_q;
  logic       acc_q;

  always_ff @(posedge clk) begin
    if (c.load) begin
      cmd_q     <= cmd;
      address_q <= address;
      block_q   <= block;
      offset_q  <= offset;
      src_q     <= src_block;
      value_q   <= value;
      busy_q    <= device_busy;
      acc_q     <= device_accepts;
    end
  end

  // Walk counter: bytes of a block, or pages of a flush
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_eff;

  assign idx_eff = c.idx_inc ? idx + 1'b1 : idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (c.load) begin
      idx <= '0;
    end else if (c.idx_inc) begin
      idx <= idx + 1'b1;
    end
  end

  // Address generation
  logic [MEM_AW-1:0] blk_base;
  logic [MEM_AW-1:0] src_base;
  logic [MEM_AW-1:0] addr_a;
  logic [MEM_AW-1:0] addr_b;
  logic [MEM_AW-1:0] dst_cur;
  logic [MEM_AW-1:0] wr_addr;

  assign blk_base = MEM_AW'({block_q, {BLK_AW{1'b0}}});
  assign src_base = MEM_AW'({src_q, {BLK_AW{1'b0}}});
  assign addr_b   = blk_base | MEM_AW'(idx_eff);
  assign dst_cur  = blk_base | MEM_AW'(idx);

  always_comb begin
    case (c.rsel)
      RS_BYTE: addr_a = MEM_AW'(address_q);
      RS_BWB:  addr_a = blk_base | MEM_AW'(offset_q);
      RS_BLK:  addr_a = blk_base | MEM_AW'(idx_eff);
      RS_SRC:  addr_a = src_base | MEM_AW'(idx_eff);
      default: addr_a = MEM_AW'(address_q);
    endcase
  end

  // Byte store, valid bits make unwritten entries read as zero
  logic [7:0]           mem [MEM_BYTES];
  logic [MEM_BYTES-1:0] vbits;
  logic [7:0]           rd_a;
  logic [7:0]           rd_b;
  logic                 rdv_a;
  logic                 rdv_b;
  logic [7:0]           cur_a;
  logic [7:0]           cur_b;
  logic                 do_write;
  logic [7:0]           wr_data;
  logic                 mark;
  logic [PG_W-1:0]      wr_page;

  assign cur_a   = rdv_a ? rd_a : 8'd0;
  assign cur_b   = rdv_b ? rd_b : 8'd0;
  assign wr_addr = (c.wk == WK_COPY) ? dst_cur : addr_a;
  assign wr_data = (c.wk == WK_COPY) ? cur_a : value_q;
  assign wr_page = PG_W'(wr_addr >> PAGE_AW);

  always_comb begin
    case (c.wk)
      WK_MARK: do_write = (cur_a != value_q);
      WK_FILL: do_write = 1'b1;
      WK_COPY: do_write = (cur_a != cur_b);
      default: do_write = 1'b0;
    endcase
  end

  assign mark = do_write && (c.wk != WK_FILL);

  always_ff @(posedge clk) begin
    if (c.rd_en) begin
      rd_a  <= mem[addr_a];
      rd_b  <= mem[addr_b];
      rdv_a <= vbits[addr_a];
      rdv_b <= vbits[addr_b];
    end
    if (do_write) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vbits <= '0;
    end else if (do_write) begin
      vbits[wr_addr] <= 1'b1;
    end
  end

  // Dirty bits and commit pointer
  logic [NPAGES-1:0] dirty;
  logic [PG_W-1:0]   ptr;
  logic [PG_W-1:0]   ptr_inc;
  logic [PG_W-1:0]   flush_pg;
  logic [NPAGES-1:0] higher;
  logic              commit_em;
  logic              commit_adv;
  logic              commit_wr;

  assign flush_pg   = PG_W'(idx);
  assign ptr_inc    = (ptr == PG_W'(NPAGES - 1)) ? '0 : ptr + 1'b1;
  assign higher     = dirty & ~NPAGES'((33'd2 << idx) - 33'd1);
  assign commit_em  = c.emit && (c.kind == EK_COMMIT);
  assign commit_wr  = commit_em && !busy_q && dirty[ptr] && acc_q;
  assign commit_adv = commit_em && !busy_q && (!dirty[ptr] || acc_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      dirty <= '0;
      ptr   <= '0;
    end else begin
      if (mark) begin
        dirty[wr_page] <= 1'b1;
      end
      if (c.emit && c.kind == EK_FLUSH) begin
        dirty[flush_pg] <= 1'b0;
      end
      if (commit_wr) begin
        dirty[ptr] <= 1'b0;
      end
      if (commit_adv) begin
        ptr <= ptr_inc;
      end
    end
  end

  // Result fields of the beat being formed
  logic [7:0]      o_data;
  logic [PG_W-1:0] o_page;
  logic            o_pw;
  logic [1:0]      o_status;

  always_comb begin
    o_data   = 8'd0;
    o_page   = '0;
    o_pw     = 1'b0;
    o_status = ST_OK;
    case (c.kind)
      EK_ERR:  o_status = ST_BAD;
      EK_BUSY: o_status = ST_BUSY;
      EK_BYTE: o_data = cur_a;
      EK_FLUSH: begin
        o_page = flush_pg;
        o_pw   = 1'b1;
      end
      EK_COMMIT: begin
        if (busy_q) begin
          o_status = ST_BUSY;
        end else if (dirty[ptr] && !acc_q) begin
          o_status = ST_REFUSED;
        end else if (dirty[ptr]) begin
          o_page = ptr;
          o_pw   = 1'b1;
        end
      end
      default: o_status = ST_OK;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (c.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (c.emit) begin
      data       <= o_data;
      page       <= 4'(o_page);
      page_write <= o_pw;
      status     <= o_status;
      last       <= c.last;
    end
  end

  // Status to the controller
  assign st.cmd         = cmd_q;
  assign st.addr_ok     = (address_q < 10'(MEM_BYTES));
  assign st.blk_ok      = (block_q < 8'(NBLOCKS));
  assign st.off_ok      = ({1'b0, offset_q} < 5'(BLOCK_BYTES));
  assign st.src_ok      = (src_q < 8'(NBLOCKS));
  assign st.busy        = busy_q;
  assign st.idx_last    = (idx == IDX_W'(BLOCK_BYTES - 1));
  assign st.out_free    = !out_valid || !out_stall;
  assign st.any_dirty   = |dirty;
  assign st.flush_dirty = dirty[flush_pg];
  assign st.flush_more  = |higher;

  // Checks
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    c.emit |-> (!out_valid || !out_stall))
    else $error("beat loaded while result register is held");
  a_pw_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && page_write |-> status == ST_OK)
    else $error("page request with non-ok status");
  a_data_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (data != 8'd0) |-> (status == ST_OK) && !page_write)
    else $error("data byte on a non-read beat");
  a_write_beat: assert property (@(posedge clk) disable iff (rst)
    do_write && c.emit |-> c.kind == EK_OK)
    else $error("store write on a beat that is not a plain ok");

endmodule

FILE: sv/esdpb_ctrl.sv
// Controller state machine: decodes the latched item and sequences store
// accesses, block walks and result beats. Depends on esdpb_pkg.
module esdpb_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  esdpb_pkg::dp_status_t  st,
  output esdpb_pkg::ctrl_cmd_t   c
);
  import esdpb_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_BRD   = 3'd3;
  localparam logic [2:0] S_CPRD  = 3'd4;
  localparam logic [2:0] S_CPWR  = 3'd5;
  localparam logic [2:0] S_FLUSH = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] ekind;
  logic [2:0] ekind_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ekind <= EK_OK;
    end else begin
      state <= state_next;
      ekind <= ekind_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  // Next state and datapath commands
  always_comb begin
    c          = '0;
    state_next = state;
    ekind_next = ekind;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          c.load     = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        case (st.cmd)
          CMD_READ, CMD_WRITE, CMD_FILL: begin
            if (!st.addr_ok) begin
              ekind_next = EK_ERR;
              state_next = S_EMIT;
            end else begin
              c.rd_en    = 1'b1;
              c.rsel     = RS_BYTE;
              state_next = S_ACC;
            end
          end
          CMD_BLK_WR: begin
            if (!st.blk_ok || !st.off_ok) begin
              ekind_next = EK_ERR;
              state_next = S_EMIT;
            end else begin
              c.rd_en    = 1'b1;
              c.rsel     = RS_BWB;
              state_next = S_ACC;
            end
          end
          CMD_BLK_RD: begin
            if (!st.blk_ok) begin
              ekind_next = EK_ERR;
              state_next = S_EMIT;
            end else begin
              c.rd_en    = 1'b1;
              c.rsel     = RS_BLK;
              state_next = S_BRD;
            end
          end
          CMD_COPY: begin
            if (!st.blk_ok || !st.src_ok) begin
              ekind_next = EK_ERR;
              state_next = S_EMIT;
            end else begin
              state_next = S_CPRD;
            end
          end
          CMD_COMMIT: begin
            ekind_next = EK_COMMIT;
            state_next = S_EMIT;
          end
          default: begin
            if (st.busy) begin
              ekind_next = EK_BUSY;
              state_next = S_EMIT;
            end else if (!st.any_dirty) begin
              ekind_next = EK_OK;
              state_next = S_EMIT;
            end else begin
              state_next = S_FLUSH;
            end
          end
        endcase
      end
      // single byte: write back at the same time as the beat goes out
      S_ACC: begin
        c.rsel = (st.cmd == CMD_BLK_WR) ? RS_BWB : RS_BYTE;
        if (st.out_free) begin
          c.emit = 1'b1;
          c.last = 1'b1;
          c.kind = (st.cmd == CMD_READ) ? EK_BYTE : EK_OK;
          case (st.cmd)
            CMD_WRITE, CMD_BLK_WR: c.wk = WK_MARK;
            CMD_FILL:              c.wk = WK_FILL;
            default:               c.wk = WK_NONE;
          endcase
          state_next = S_IDLE;
        end
      end
      // block read: one byte a beat, next read issued with each beat
      S_BRD: begin
        if (st.out_free) begin
          c.emit = 1'b1;
          c.kind = EK_BYTE;
          c.last = st.idx_last;
          if (st.idx_last) begin
            state_next = S_IDLE;
          end else begin
            c.idx_inc = 1'b1;
            c.rd_en   = 1'b1;
            c.rsel    = RS_BLK;
          end
        end
      end
      S_CPRD: begin
        c.rd_en    = 1'b1;
        c.rsel     = RS_SRC;
        state_next = S_CPWR;
      end
      S_CPWR: begin
        c.wk = WK_COPY;
        if (st.idx_last) begin
          ekind_next = EK_OK;
          state_next = S_EMIT;
        end else begin
          c.idx_inc  = 1'b1;
          state_next = S_CPRD;
        end
      end
      // flush: walk pages, one beat per dirty page
      S_FLUSH: begin
        if (st.flush_dirty) begin
          if (st.out_free) begin
            c.emit = 1'b1;
            c.kind = EK_FLUSH;
            c.last = !st.flush_more;
            if (!st.flush_more) begin
              state_next = S_IDLE;
            end else begin
              c.idx_inc = 1'b1;
            end
          end
        end else begin
          c.idx_inc = 1'b1;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          c.emit     = 1'b1;
          c.kind     = ekind;
          c.last     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Checks
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    c.emit && c.last |=> state == S_IDLE)
    else $error("final beat did not end the item");
  a_copy_order: assert property (@(posedge clk) disable iff (rst)
    state == S_CPWR |-> $past(state) == S_CPRD)
    else $error("copy write without a preceding read");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Testbench for eeprom_shadow_dirty_page_buffer: a directed command table, then
// random commands, every result beat checked against a behavioral shadow store.
// Depends on esdpb_pkg and the block RTL.
module tb;
  import esdpb_pkg::*;

  localparam int MAX_FLUSH_PAGES = 16;
  localparam int RANDOM_ITEMS    = 405;

  typedef struct packed {
    logic [2:0] cmd;
    logic [9:0] address;
    logic [7:0] block;
    logic [3:0] offset;
    logic [7:0] src_block;
    logic [7:0] value;
    logic       device_busy;
    logic       device_accepts;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic [3:0] page;
    logic       page_write;
    logic [1:0] status;
    logic       last;
  } result_beat_t;

  // One directed row: a command, and a hand-written result where it is obvious
  typedef struct packed {
    cmd_item_t    item;
    logic         typed;
    result_beat_t beat;
  } dir_row_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [2:0] cmd;
  logic [9:0] address;
  logic [7:0] block;
  logic [3:0] offset;
  logic [7:0] src_block;
  logic [7:0] value;
  logic       device_busy;
  logic       device_accepts;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] data;
  logic [3:0] page;
  logic       page_write;
  logic [1:0] status;
  logic       last;

  // Shadow image, dirty pages and commit pointer as the block should hold them
  logic [7:0]   img_bytes [MEM_BYTES];
  logic         page_dirty [NPAGES];
  int           commit_ptr;
  result_beat_t expected_beats [$];

  int mismatch_count;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_request;
  int hold_left;

  eeprom_shadow_dirty_page_buffer u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .address        (address),
    .block          (block),
    .offset         (offset),
    .src_block      (src_block),
    .value          (value),
    .device_busy    (device_busy),
    .device_accepts (device_accepts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .data           (data),
    .page           (page),
    .page_write     (page_write),
    .status         (status),
    .last           (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit, far beyond the slowest legal run
  initial begin
    #3000000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic cmd_item_t mk_item(logic [2:0] c, logic [9:0] a, logic [7:0] b,
                                        logic [3:0] o, logic [7:0] s, logic [7:0] v,
                                        logic bsy, logic acc);
    cmd_item_t it;
    it.cmd = c;
    it.address = a;
    it.block = b;
    it.offset = o;
    it.src_block = s;
    it.value = v;
    it.device_busy = bsy;
    it.device_accepts = acc;
    return it;
  endfunction

  function automatic result_beat_t mk_beat(logic [7:0] d, logic [3:0] pg, logic pw,
                                           logic [1:0] st);
    result_beat_t b;
    b.data = d;
    b.page = pg;
    b.page_write = pw;
    b.status = st;
    b.last = 1'b1;
    return b;
  endfunction

  function automatic dir_row_t mk_row(cmd_item_t it, logic typed, result_beat_t b);
    dir_row_t r;
    r.item = it;
    r.typed = typed;
    r.beat = b;
    return r;
  endfunction

  function automatic void push_beat(result_beat_t b);
    b.last = 1'b0;
    expected_beats.push_back(b);
  endfunction

  function automatic bit block_in_range(logic [7:0] b);
    return int'(b) * BLOCK_BYTES + BLOCK_BYTES <= MEM_BYTES;
  endfunction

  // Byte store that marks its page dirty only on an actual change
  function automatic void mark_store(int a, logic [7:0] v);
    if (img_bytes[a] != v) begin
      img_bytes[a] = v;
      page_dirty[a / PAGE_BYTES] = 1'b1;
    end
  endfunction

  // Apply one command to the shadow state and queue the beats it should produce
  function automatic void predict_beats(cmd_item_t it);
    logic [7:0]   copy_buf [BLOCK_BYTES];
    result_beat_t tail;
    int           k;
    int           n;
    int           src_base;
    int           dst_base;
    n = 0;
    src_base = int'(it.src_block) * BLOCK_BYTES;
    dst_base = int'(it.block) * BLOCK_BYTES;
    case (it.cmd)
      CMD_READ: begin
        if (it.address >= MEM_BYTES) push_beat(mk_beat(8'd0, 4'd0, 1'b0, ST_BAD));
        else push_beat(mk_beat(img_bytes[it.address], 4'd0, 1'b0, ST_OK));
      end
      CMD_WRITE, CMD_FILL: begin
        if (it.address >= MEM_BYTES) begin
          push_beat(mk_beat(8'd0, 4'd0, 1'b0, ST_BAD));
        end else begin
          if (it.cmd == CMD_WRITE) mark_store(int'(it.address), it.value);
          else img_bytes[it.address] = it.value;
          push_beat(mk_beat(8'd0, 4'd0, 1'b0, ST_OK));
        end
      end
      CMD_BLK_RD: begin
        if (!block_in_range(it.block)) begin
          push_beat(mk_beat(8'd0, 4'd0, 1'b0, ST_BAD));
        end else begin
          for (k = 0; k < BLOCK_BYTES; k++)
            push_beat(mk_beat(img_bytes[dst_base + k], 4'd0, 1'b0, ST_OK));
        end
      end
      CMD_BLK_WR: begin
        if (!block_in_range(it.block) || int'(it.offset) >= BLOCK_BYTES) begin
          push_beat(mk_beat(8'd0, 4'd0, 1'b0, ST_BAD));
        end else begin
          mark_store(dst_base + int'(it.offset), it.value);
          push_beat(mk_beat(8'd0, 4'd0, 1'b0, ST_OK));
        end
      end
      CMD_COPY: begin
        if (!block_in_range(it.block) || !block_in_range(it.src_block)) begin
          push_beat(mk_beat(8'd0, 4'd0, 1'b0, ST_BAD));
        end else begin
          for (k = 0; k < BLOCK_BYTES; k++) copy_buf[k] = img_bytes[src_base + k];
          for (k = 0; k < BLOCK_BYTES; k++) mark_store(dst_base + k, copy_buf[k]);
          push_beat(mk_beat(8'd0, 4'd0, 1'b0, ST_OK));
        end
      end
      CMD_COMMIT: begin
        if (it.device_busy) begin
          push_beat(mk_beat(8'd0, 4'd0, 1'b0, ST_BUSY));
        end else if (!page_dirty[commit_ptr]) begin
          // clean page: nothing to write, pointer still steps
          commit_ptr = (commit_ptr + 1) % NPAGES;
          push_beat(mk_beat(8'd0, 4'd0, 1'b0, ST_OK));
        end else if (!it.device_accepts) begin
          push_beat(mk_beat(8'd0, 4'd0, 1'b0, ST_REFUSED));
        end else begin
          push_beat(mk_beat(8'd0, 4'(commit_ptr), 1'b1, ST_OK));
          page_dirty[commit_ptr] = 1'b0;
          commit_ptr = (commit_ptr + 1) % NPAGES;
        end
      end
      default: begin
        // flush ignores device_accepts
        if (it.device_busy) begin
          push_beat(mk_beat(8'd0, 4'd0, 1'b0, ST_BUSY));
        end else begin
          for (k = 0; k < NPAGES && n < MAX_FLUSH_PAGES; k++) begin
            if (page_dirty[k]) begin
              push_beat(mk_beat(8'd0, 4'(k), 1'b1, ST_OK));
              page_dirty[k] = 1'b0;
              n++;
            end
          end
          if (n == 0) push_beat(mk_beat(8'd0, 4'd0, 1'b0, ST_OK));
        end
      end
    endcase
    tail = expected_beats.pop_back();
    tail.last = 1'b1;
    expected_beats.push_back(tail);
  endfunction

  function automatic cmd_item_t random_item();
    cmd_item_t it;
    int        r;
    int        loc;
    r = $urandom_range(99);
    if (r < 20)      it.cmd = CMD_WRITE;
    else if (r < 30) it.cmd = CMD_READ;
    else if (r < 38) it.cmd = CMD_FILL;
    else if (r < 47) it.cmd = CMD_BLK_RD;
    else if (r < 62) it.cmd = CMD_BLK_WR;
    else if (r < 70) it.cmd = CMD_COPY;
    else if (r < 88) it.cmd = CMD_COMMIT;
    else             it.cmd = CMD_FLUSH;
    // mostly in range, sometimes out of range
    it.address = ($urandom_range(99) < 85) ? 10'($urandom_range(MEM_BYTES - 1))
                                           : 10'($urandom_range(1023, MEM_BYTES));
    it.block = ($urandom_range(99) < 85) ? 8'($urandom_range(NBLOCKS - 1))
                                         : 8'($urandom_range(255, NBLOCKS));
    it.src_block = ($urandom_range(99) < 85) ? 8'($urandom_range(NBLOCKS - 1))
                                             : 8'($urandom_range(255, NBLOCKS));
    it.offset = 4'($urandom_range(15));
    it.value = 8'($urandom_range(255));
    it.device_busy = ($urandom_range(99) < 20);
    it.device_accepts = ($urandom_range(99) < 80);
    // rewrite the current byte now and then, so the no-change path is hit
    loc = -1;
    if (it.cmd == CMD_WRITE && it.address < MEM_BYTES) loc = int'(it.address);
    if (it.cmd == CMD_BLK_WR && block_in_range(it.block))
      loc = int'(it.block) * BLOCK_BYTES + int'(it.offset);
    if (loc >= 0 && $urandom_range(99) < 25) it.value = img_bytes[loc];
    return it;
  endfunction

  task automatic note_mismatch(string field, int got, int want);
    $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $realtime, field, got, want);
    mismatch_count++;
  endtask

  // Offer one command beat, wait for it to be taken, then queue its results
  task automatic send_item(cmd_item_t it, logic typed, result_beat_t b);
    int gap;
    int depth;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= it.cmd;
    address <= it.address;
    block <= it.block;
    offset <= it.offset;
    src_block <= it.src_block;
    value <= it.value;
    device_busy <= it.device_busy;
    device_accepts <= it.device_accepts;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    depth = expected_beats.size();
    predict_beats(it);
    if (typed) begin
      // state follows the predictor, the beat is the hand-written one
      while (expected_beats.size() > depth) void'(expected_beats.pop_back());
      expected_beats.push_back(b);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  // Result side: check each accepted beat, drive stall
  initial begin
    result_beat_t want;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          // beat with nothing outstanding
          note_mismatch("unexpected beat", data, 0);
        end else begin
          want = expected_beats.pop_front();
          if (data != want.data) note_mismatch("data", data, want.data);
          if (page != want.page) note_mismatch("page", page, want.page);
          if (page_write != want.page_write)
            note_mismatch("page_write", page_write, want.page_write);
          if (status != want.status) note_mismatch("status", status, want.status);
          if (last != want.last) note_mismatch("last", last, want.last);
        end
      end
      if (hold_request != 0) begin
        hold_left = 400;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Stimulus
  initial begin
    dir_row_t     rows [$];
    result_beat_t none;
    int           i;
    none = '0;
    mismatch_count = 0;
    hold_request = 0;
    send_idle_pct = 23;
    recv_stall_pct = 60;
    commit_ptr = 0;
    for (i = 0; i < MEM_BYTES; i++) img_bytes[i] = 8'd0;
    for (i = 0; i < NPAGES; i++) page_dirty[i] = 1'b0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    cmd <= CMD_READ;
    address <= '0;
    block <= '0;
    offset <= '0;
    src_block <= '0;
    value <= '0;
    device_busy <= 1'b0;
    device_accepts <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    rows.push_back(mk_row(mk_item(CMD_READ, 10'd0, 8'd0, 4'd0, 8'd0, 8'h00, 1'b0, 1'b0),
                          1'b1, mk_beat(8'h00, 4'd0, 1'b0, ST_OK)));
    rows.push_back(mk_row(mk_item(CMD_READ, 10'd1023, 8'd0, 4'd0, 8'd0, 8'h00, 1'b0, 1'b0),
                          1'b1, mk_beat(8'h00, 4'd0, 1'b0, ST_BAD)));
    rows.push_back(mk_row(mk_item(CMD_READ, 10'd256, 8'd0, 4'd0, 8'd0, 8'h00, 1'b0, 1'b0),
                          1'b1, mk_beat(8'h00, 4'd0, 1'b0, ST_BAD)));
    rows.push_back(mk_row(mk_item(CMD_WRITE, 10'd255, 8'd0, 4'd0, 8'd0, 8'hFF, 1'b0, 1'b1),
                          1'b1, mk_beat(8'h00, 4'd0, 1'b0, ST_OK)));
    rows.push_back(mk_row(mk_item(CMD_WRITE, 10'd255, 8'd0, 4'd0, 8'd0, 8'hFF, 1'b1, 1'b0),
                          1'b1, mk_beat(8'h00, 4'd0, 1'b0, ST_OK)));
    rows.push_back(mk_row(mk_item(CMD_FILL, 10'd0, 8'd0, 4'd0, 8'd0, 8'hA5, 1'b0, 1'b0),
                          1'b1, mk_beat(8'h00, 4'd0, 1'b0, ST_OK)));
    rows.push_back(mk_row(mk_item(CMD_READ, 10'd0, 8'd0, 4'd0, 8'd0, 8'h00, 1'b0, 1'b0),
                          1'b1, mk_beat(8'hA5, 4'd0, 1'b0, ST_OK)));
    rows.push_back(mk_row(mk_item(CMD_WRITE, 10'd256, 8'd0, 4'd0, 8'd0, 8'h11, 1'b0, 1'b0),
                          1'b1, mk_beat(8'h00, 4'd0, 1'b0, ST_BAD)));
    rows.push_back(mk_row(mk_item(CMD_FILL, 10'd1023, 8'd0, 4'd0, 8'd0, 8'h22, 1'b0, 1'b0),
                          1'b1, mk_beat(8'h00, 4'd0, 1'b0, ST_BAD)));
    rows.push_back(mk_row(mk_item(CMD_BLK_RD, 10'd0, 8'd0, 4'd0, 8'd0, 8'h00, 1'b0, 1'b0),
                          1'b0, none));
    rows.push_back(mk_row(mk_item(CMD_BLK_RD, 10'd0, 8'd255, 4'd0, 8'd0, 8'h00, 1'b0, 1'b0),
                          1'b1, mk_beat(8'h00, 4'd0, 1'b0, ST_BAD)));
    rows.push_back(mk_row(mk_item(CMD_BLK_WR, 10'd0, 8'd15, 4'd15, 8'd0, 8'h5A, 1'b0, 1'b0),
                          1'b1, mk_beat(8'h00, 4'd0, 1'b0, ST_OK)));
    rows.push_back(mk_row(mk_item(CMD_BLK_WR, 10'd0, 8'd16, 4'd0, 8'd0, 8'h33, 1'b0, 1'b0),
                          1'b1, mk_beat(8'h00, 4'd0, 1'b0, ST_BAD)));
    rows.push_back(mk_row(mk_item(CMD_BLK_WR, 10'd0, 8'd0, 4'd0, 8'd0, 8'h00, 1'b0, 1'b0),
                          1'b1, mk_beat(8'h00, 4'd0, 1'b0, ST_OK)));
    rows.push_back(mk_row(mk_item(CMD_COPY, 10'd0, 8'd1, 4'd0, 8'd15, 8'h00, 1'b0, 1'b0),
                          1'b1, mk_beat(8'h00, 4'd0, 1'b0, ST_OK)));
    // copy onto itself
    rows.push_back(mk_row(mk_item(CMD_COPY, 10'd0, 8'd3, 4'd0, 8'd3, 8'h00, 1'b0, 1'b0),
                          1'b1, mk_beat(8'h00, 4'd0, 1'b0, ST_OK)));
    rows.push_back(mk_row(mk_item(CMD_COPY, 10'd0, 8'd255, 4'd0, 8'd0, 8'h00, 1'b0, 1'b0),
                          1'b1, mk_beat(8'h00, 4'd0, 1'b0, ST_BAD)));
    rows.push_back(mk_row(mk_item(CMD_COPY, 10'd0, 8'd0, 4'd0, 8'd16, 8'h00, 1'b0, 1'b0),
                          1'b1, mk_beat(8'h00, 4'd0, 1'b0, ST_BAD)));
    rows.push_back(mk_row(mk_item(CMD_COMMIT, 10'd0, 8'd0, 4'd0, 8'd0, 8'h00, 1'b1, 1'b1),
                          1'b1, mk_beat(8'h00, 4'd0, 1'b0, ST_BUSY)));
    // commits: dirty page written, then refused, then the same page written
    rows.push_back(mk_row(mk_item(CMD_COMMIT, 10'd0, 8'd0, 4'd0, 8'd0, 8'h00, 1'b0, 1'b1),
                          1'b0, none));
    rows.push_back(mk_row(mk_item(CMD_COMMIT, 10'd0, 8'd0, 4'd0, 8'd0, 8'h00, 1'b0, 1'b0),
                          1'b0, none));
    rows.push_back(mk_row(mk_item(CMD_COMMIT, 10'd0, 8'd0, 4'd0, 8'd0, 8'h00, 1'b0, 1'b1),
                          1'b0, none));
    rows.push_back(mk_row(mk_item(CMD_FLUSH, 10'd0, 8'd0, 4'd0, 8'd0, 8'h00, 1'b1, 1'b1),
                          1'b1, mk_beat(8'h00, 4'd0, 1'b0, ST_BUSY)));
    rows.push_back(mk_row(mk_item(CMD_FLUSH, 10'd0, 8'd0, 4'd0, 8'd0, 8'h00, 1'b0, 1'b0),
                          1'b0, none));
    // nothing left dirty
    rows.push_back(mk_row(mk_item(CMD_FLUSH, 10'd0, 8'd0, 4'd0, 8'd0, 8'h00, 1'b0, 1'b1),
                          1'b1, mk_beat(8'h00, 4'd0, 1'b0, ST_OK)));
    foreach (rows[j]) send_item(rows[j].item, rows[j].typed, rows[j].beat);

    // Random commands in three idling phases
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        send_idle_pct = 60;
        recv_stall_pct = 23;
      end
      if (i == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      // long output hold while commands keep coming, to back the block up
      if (i == 60) hold_request = 1;
      // sender waits for every outstanding beat
      if (i == 200) wait_drained();
      send_item(random_item(), 1'b0, none);
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
